/* hw/rtl/bounded_list_insert_delete_assert.svh */
// Assertion macros shared by the bounded list checker.
`ifndef BOUNDED_LIST_INSERT_DELETE_ASSERT_SVH
`define BOUNDED_LIST_INSERT_DELETE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BLI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BLI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/bli_pkg.sv */
// Types and constants for the bounded list block.
package bli_pkg;

	localparam int BLI_CAPACITY = 64;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SHIFT,
		ST_SHIFT_END,
		ST_LIST
	} state_t;

	// One listing result waiting in the output queue.
	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
		logic               empty;
		logic               ovf;
	} entry_t;

endpackage

/* hw/rtl/bli_addr_unit.sv */
// Circular-buffer address unit: head plus offset, wrapped at the capacity.
module bli_addr_unit import bli_pkg::*; #(
	parameter int CAPACITY = BLI_CAPACITY
) (
	input  logic [$clog2(CAPACITY)-1:0]   base,
	input  logic [$clog2(CAPACITY+1)-1:0] offset,
	output logic [$clog2(CAPACITY)-1:0]   addr
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW:0] sum;
	logic [CW:0] wrapped;

	// base < CAPACITY and offset <= CAPACITY, so one subtract is enough
	always_comb begin
		sum     = (CW + 1)'(base) + (CW + 1)'(offset);
		wrapped = (sum >= (CW + 1)'(CAPACITY)) ? sum - (CW + 1)'(CAPACITY) : sum;
		addr    = wrapped[AW-1:0];
	end

endmodule

/* hw/rtl/bounded_list_insert_delete.sv */
// Bounded ordered list with insert, append, delete and full listing.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | op, operand
//  out     | out_valid / out_ready| element_value, is_last, list_empty, overflow
//
// Insert/append: accept, a single execute state, then the listing (n results,
//   or one when empty) streams at one result per cycle while out_ready holds.
// Delete at position p before the tail: ST_SHIFT, then ST_SHIFT_END, move the tail
//   down one slot through the single memory port pair, one entry per cycle.
// Reset clears head, count and queue state; the entry memory is left as is.
// Output stalls only throttle listing reads; a 2-entry queue keeps the rate.
module bounded_list_insert_delete import bli_pkg::*; #(
	parameter int CAPACITY = BLI_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic signed [31:0] operand,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] element_value,
	output logic               is_last,
	output logic               list_empty,
	output logic               overflow
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	state_t state_q, state_nxt;

	// list bookkeeping: circular buffer, front at head_q
	logic [AW-1:0] head_q;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;

	// request latched on accept
	logic [1:0]  op_q;
	logic [31:0] operand_q;

	// tail shift walker
	logic [CW-1:0] sidx_q;
	logic [AW-1:0] wdst_q;
	logic [AW-1:0] ra_s1;
	logic          pend_s1;

	// listing walker and read in flight
	logic [CW-1:0] lidx_q;
	logic          lp_q;
	logic          lp_last_q;
	logic          lp_empty_q;

	// entry memory
	logic [31:0] mem [CAPACITY];
	logic [31:0] rdata_q;

	// output queue, slot 0 is the head
	entry_t     fifo_q [2];
	logic [1:0] fcnt_q;

	// shared address unit
	logic [CW-1:0] unit_off;
	logic [AW-1:0] unit_addr;

	// decoded conditions
	logic          cnt_full;
	logic          cnt_zero;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] pos;
	logic          pos_ok;
	logic          pos_is_tail;
	logic          is_ins;
	logic [AW-1:0] head_dec;
	logic          pop;
	logic          push;
	logic [2:0]    occ;
	logic          issue_ok;
	logic          wr_slot;
	logic [1:0]    fill;
	entry_t        new_entry;

	// control outputs of the sequencer
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          mem_re;
	logic          lst_issue;

	bli_addr_unit #(
		.CAPACITY(CAPACITY)
	) u_addr (
		.base  (head_q),
		.offset(unit_off),
		.addr  (unit_addr)
	);

	always_comb begin
		cnt_full    = (cnt_q == CW'(CAPACITY));
		cnt_zero    = (cnt_q == '0);
		cnt_m1      = cnt_q - CW'(1);
		pos         = operand_q[CW-1:0];
		// negative positions have the sign bit set and fall out here
		pos_ok      = !operand_q[31] && (operand_q[30:0] < 31'(cnt_q));
		pos_is_tail = (pos == cnt_m1);
		is_ins      = (op_q == OP_INSERT) || (op_q == OP_APPEND);
		head_dec    = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);
	end

	// offset into the list for the one address add of this cycle
	always_comb begin
		unique case (state_q)
			ST_EXEC:  unit_off = (op_q == OP_APPEND) ? cnt_q : pos;
			ST_SHIFT: unit_off = sidx_q;
			default:  unit_off = lidx_q;
		endcase
	end

	// queue occupancy including the read in flight, after this cycle's pop
	always_comb begin
		pop      = out_valid && out_ready;
		push     = lp_q;
		occ      = 3'(fcnt_q) + 3'(lp_q) - 3'(pop);
		issue_ok = (occ <= 3'd1);
		fill     = fcnt_q - 2'(pop);
		wr_slot  = fill[0];
		new_entry.value = lp_empty_q ? '0 : rdata_q;
		new_entry.last  = lp_last_q;
		new_entry.empty = lp_empty_q;
		new_entry.ovf   = ovf_q;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				if (op_q == OP_DELETE && pos_ok && !pos_is_tail)
					state_nxt = ST_SHIFT;
				else
					state_nxt = ST_LIST;
			end
			ST_SHIFT: begin
				if (sidx_q == cnt_m1)
					state_nxt = ST_SHIFT_END;
			end
			ST_SHIFT_END: begin
				state_nxt = ST_LIST;
			end
			ST_LIST: begin
				if (issue_ok && (cnt_zero || lidx_q == cnt_m1))
					state_nxt = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		mem_re    = 1'b0;
		lst_issue = 1'b0;
		// a pending shift write always wins the write port
		mem_we    = pend_s1;
		mem_waddr = wdst_q;
		mem_wdata = rdata_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_EXEC: begin
				if (is_ins && !cnt_full) begin
					mem_we    = 1'b1;
					mem_waddr = (op_q == OP_INSERT) ? head_dec : unit_addr;
					mem_wdata = operand_q;
				end
			end
			ST_SHIFT: begin
				mem_re = 1'b1;
			end
			ST_SHIFT_END: begin
			end
			ST_LIST: begin
				lst_issue = issue_ok;
				mem_re    = issue_ok && !cnt_zero;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			pend_s1 <= 1'b0;
			lp_q    <= 1'b0;
			fcnt_q  <= '0;
		end else begin
			state_q <= state_nxt;
			pend_s1 <= (state_q == ST_SHIFT);
			lp_q    <= lst_issue;
			fcnt_q  <= fcnt_q + 2'(push) - 2'(pop);
			if (state_q == ST_EXEC) begin
				ovf_q <= is_ins && cnt_full;
				if (is_ins && !cnt_full) begin
					cnt_q <= cnt_q + CW'(1);
					if (op_q == OP_INSERT)
						head_q <= head_dec;
				end else if (op_q == OP_DELETE && pos_ok && pos_is_tail) begin
					cnt_q <= cnt_m1;
				end
			end else if (state_q == ST_SHIFT_END) begin
				cnt_q <= cnt_m1;
			end
		end
	end

	// request capture, walkers and queue payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q      <= op;
			operand_q <= operand;
		end
		if (state_q == ST_EXEC) begin
			lidx_q <= '0;
			sidx_q <= pos + CW'(1);
			wdst_q <= unit_addr;
		end
		if (state_q == ST_SHIFT) begin
			sidx_q <= sidx_q + CW'(1);
			ra_s1  <= unit_addr;
		end
		if (pend_s1)
			wdst_q <= ra_s1;
		if (lst_issue) begin
			lidx_q     <= lidx_q + CW'(1);
			lp_last_q  <= cnt_zero || (lidx_q == cnt_m1);
			lp_empty_q <= cnt_zero;
		end
		// a push into the head slot replaces the shift from slot 1
		if (push && !wr_slot)
			fifo_q[0] <= new_entry;
		else if (pop)
			fifo_q[0] <= fifo_q[1];
		if (push && wr_slot)
			fifo_q[1] <= new_entry;
	end

	// entry memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata_q <= mem[unit_addr];
	end

	assign out_valid     = (fcnt_q != '0);
	assign element_value = fifo_q[0].value;
	assign is_last       = fifo_q[0].last;
	assign list_empty    = fifo_q[0].empty;
	assign overflow      = fifo_q[0].ovf;

endmodule

/* hw/rtl/bli_checker.sv */
// Port-level checks for the bounded list block, bound to the top level.
`include "bounded_list_insert_delete_assert.svh"

module bli_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] element_value,
	input logic               is_last,
	input logic               list_empty,
	input logic               overflow
);

	// stalled result holds
	`BLI_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(element_value) && $stable(is_last), "stalled result changed")

	// empty listing is a single zero result
	`BLI_ASSERT_IMP(a_empty_form, out_valid && list_empty, is_last && element_value == 32'sd0, "empty result malformed")

	// a dropped insert means the list was full, never empty
	`BLI_ASSERT_IMP(a_empty_no_ovf, out_valid && list_empty, !overflow, "overflow on empty list")

	// a request makes the block busy in the cycle after it is accepted
	`BLI_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready right after request")

endmodule

bind bounded_list_insert_delete bli_checker u_bli_checker (.*);
